@@ hdl/wpm_pkg.sv @@
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types and constants for the word list prefix matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

  localparam int MAX_WORDS_DEF = 64;
  localparam int MAX_LEN_DEF   = 32;
  localparam int CHAR_W        = 8;

  // action codes of an input beat
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // control part of a token travelling down the cell chain
  typedef struct packed {
    logic valid;
    logic query;
    logic last;
    logic any;
  } wpm_ctl_t;

endpackage

@@ hdl/wpm_in_if.sv @@
// ----------------------------------------------------------------------------
// wpm_in_if
// Input channel: one character beat, for loading a word or for a query.
// ----------------------------------------------------------------------------
interface wpm_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [wpm_pkg::CHAR_W-1:0] char_code;
  logic                       last;

  modport source (output valid, output action, output char_code, output last,
                  input ready);
  modport sink   (input valid, input action, input char_code, input last,
                  output ready);
endinterface

@@ hdl/wpm_out_if.sv @@
// ----------------------------------------------------------------------------
// wpm_out_if
// Output channel: one match flag per finished query.
// ----------------------------------------------------------------------------
interface wpm_out_if;
  logic valid;
  logic ready;
  logic match;

  modport source (output valid, output match, input ready);
  modport sink   (input valid, input match, output ready);
endinterface

@@ hdl/wpm_cell.sv @@
// ----------------------------------------------------------------------------
// wpm_cell
// One word slot of the chain: stores a word, compares it against the query
// stream and hands each token it does not absorb on to the next slot.
// ----------------------------------------------------------------------------
module wpm_cell #(
  parameter int MAX_LEN = wpm_pkg::MAX_LEN_DEF,
  localparam int PW = $clog2(MAX_LEN + 1),
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  localparam int DEPTH = 1 << AW
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  wpm_pkg::wpm_ctl_t          ci,
  input  logic [wpm_pkg::CHAR_W-1:0] ch_i,
  input  logic [PW-1:0]              pos_i,
  output wpm_pkg::wpm_ctl_t          co,
  output logic [wpm_pkg::CHAR_W-1:0] ch_o,
  output logic [PW-1:0]              pos_o
);

  wpm_pkg::wpm_ctl_t          tq;
  logic [wpm_pkg::CHAR_W-1:0] ch_q;
  logic [PW-1:0]              pos_q;
  logic [wpm_pkg::CHAR_W-1:0] rd;
  logic [wpm_pkg::CHAR_W-1:0] mem [DEPTH];

  logic          filled, filled_next;
  logic          sm, sm_next;
  logic [PW-1:0] len, len_next;
  logic [PW-1:0] lp, lp_next;

  logic          absorb, we, cmp, in_range, miss, sm_cur, hit;
  logic [PW-1:0] lp_inc, seen;
  logic [AW-1:0] wa, ra;

  assign wa = lp[AW-1:0];
  assign ra = pos_i[AW-1:0];

  always_comb begin
    absorb   = tq.valid && (tq.query == wpm_pkg::ACT_LOAD) && !filled;
    we       = absorb && (lp < PW'(MAX_LEN));
    lp_inc   = we ? lp + PW'(1) : lp;
    cmp      = tq.valid && (tq.query == wpm_pkg::ACT_QUERY) && filled;
    in_range = pos_q < PW'(MAX_LEN);
    miss     = cmp && in_range && (pos_q < len) && (rd != ch_q);
    sm_cur   = sm && !miss;
    seen     = in_range ? pos_q + PW'(1) : pos_q;
    hit      = cmp && tq.last && sm_cur && (len <= seen);

    filled_next = filled;
    sm_next     = sm;
    len_next    = len;
    lp_next     = lp;
    if (absorb) begin
      lp_next = tq.last ? '0 : lp_inc;
      if (tq.last) begin
        // a word closed while a query runs joins from the next query on
        filled_next = 1'b1;
        len_next    = lp_inc;
        sm_next     = (pos_q == '0);
      end
    end
    if (cmp) begin
      sm_next = tq.last ? 1'b1 : sm_cur;
    end

    co       = tq;
    co.valid = tq.valid && !absorb;
    co.any   = tq.any | hit;
    ch_o     = ch_q;
    pos_o    = pos_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tq     <= '0;
      filled <= 1'b0;
      sm     <= 1'b1;
      len    <= '0;
      lp     <= '0;
    end else if (adv) begin
      tq     <= ci;
      filled <= filled_next;
      sm     <= sm_next;
      len    <= len_next;
      lp     <= lp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ch_q  <= ch_i;
      pos_q <= pos_i;
    end
  end

  // character store, write-first so a closing char is seen by the next beat
  always_ff @(posedge clk) begin
    if (adv) begin
      if (we) begin
        mem[wa] <= ch_q;
      end
      rd <= (we && (wa == ra)) ? ch_q : mem[ra];
    end
  end

  a_stays_closed: assert property (@(posedge clk) disable iff (rst)
    filled |=> filled) else $error("closed word slot reopened");
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    filled |-> (len != '0)) else $error("closed word has zero length");
  a_lp_bound: assert property (@(posedge clk) disable iff (rst)
    lp <= PW'(MAX_LEN)) else $error("load position past word limit");

endmodule

@@ hdl/wpm_obuf.sv @@
// ----------------------------------------------------------------------------
// wpm_obuf
// Two-entry result buffer between the cell chain and the output channel.
// ----------------------------------------------------------------------------
module wpm_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              push_match,
  output logic              room,
  wpm_out_if.source         results
);

  logic       slot [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       pop;

  assign pop           = results.valid && results.ready;
  assign room          = (cnt != 2'd2) || results.ready;
  assign results.valid = (cnt != 2'd0);
  assign results.match = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= push_match;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> room) else $error("result pushed into full buffer");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3) else $error("result count out of range");
  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (cnt == $past(cnt) - 2'd1))
    else $error("pop did not drain buffer");

endmodule

@@ hdl/word_list_prefix_matcher.sv @@
// ----------------------------------------------------------------------------
// word_list_prefix_matcher
// Streams query strings against a table of stored words and flags a query
// when some stored word is a prefix of it.
// ----------------------------------------------------------------------------
// The block is a chain of MAX_WORDS word slots. Every input beat becomes a
// token that walks down the chain one slot per cycle unless stalled, so the
// block then takes one beat every cycle; a result passes every slot register
// and the result buffer. Load beats (action 0) are absorbed by the first slot
// that has no closed word yet; that slot appends the character (characters
// past MAX_LEN are dropped) and closes the word on last. Once all slots hold
// a word further load beats fall off the end of the chain unused. Query
// beats (action 1) visit every slot in turn; each closed slot clears its
// match flag on a differing character and, on last, ORs "still matching and
// no longer than the query" into the token. A word closed while a query is
// in progress takes part from the next query on. One match beat comes out
// per query beat with last set. A two-entry result buffer keeps the chain
// moving while one result waits; the chain stalls only when both entries
// are taken and the output is not ready. The per-slot character store needs
// no clearing after reset.
// ----------------------------------------------------------------------------
module word_list_prefix_matcher #(
  parameter int MAX_WORDS = wpm_pkg::MAX_WORDS_DEF,
  parameter int MAX_LEN   = wpm_pkg::MAX_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst,
  wpm_in_if.sink    items,
  wpm_out_if.source results
);

  localparam int PW = $clog2(MAX_LEN + 1);

  // token chain: index i feeds slot i, index MAX_WORDS leaves the last slot
  wpm_pkg::wpm_ctl_t          c   [MAX_WORDS+1];
  logic [wpm_pkg::CHAR_W-1:0] ch  [MAX_WORDS+1];
  logic [PW-1:0]              pos [MAX_WORDS+1];

  logic          adv;      // whole chain moves one slot
  logic          accept;   // input beat taken
  logic          push;     // finished query leaves the chain
  logic [PW-1:0] qpos;     // query characters seen, saturating at MAX_LEN

  assign items.ready = adv;
  assign accept      = items.valid && adv;

  // entry token; the query position rides along so each slot compares the
  // right character and a closing load knows whether a query is open
  always_comb begin
    c[0].valid = accept;
    c[0].query = (items.action == wpm_pkg::ACT_QUERY);
    c[0].last  = items.last;
    c[0].any   = 1'b0;
    ch[0]      = items.char_code;
    pos[0]     = qpos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qpos <= '0;
    end else if (accept && (items.action == wpm_pkg::ACT_QUERY)) begin
      if (items.last) begin
        qpos <= '0;
      end else if (qpos < PW'(MAX_LEN)) begin
        qpos <= qpos + PW'(1);
      end
    end
  end

  // row of word slots
  for (genvar i = 0; i < MAX_WORDS; i++) begin : g_cell
    wpm_cell #(
      .MAX_LEN (MAX_LEN)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .adv   (adv),
      .ci    (c[i]),
      .ch_i  (ch[i]),
      .pos_i (pos[i]),
      .co    (c[i+1]),
      .ch_o  (ch[i+1]),
      .pos_o (pos[i+1])
    );
  end

  // only a query token with last set carries a result out of the chain
  assign push = adv && c[MAX_WORDS].valid && c[MAX_WORDS].query && c[MAX_WORDS].last;

  wpm_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_match (c[MAX_WORDS].any),
    .room       (adv),
    .results    (results)
  );

endmodule
